### sv/cau_pkg.sv
// shared constants and types of the complex arithmetic unit
package cau_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAG_BITS   = 2 * WORD_BITS;
   localparam int SHIFT_BITS = WORD_BITS - FRAC_BITS;

   typedef enum logic [2:0] {
      KIND_ADD  = 3'd0,
      KIND_SUB  = 3'd1,
      KIND_MUL  = 3'd2,
      KIND_DIV  = 3'd3,
      KIND_CONJ = 3'd4
   } kind_type;

   // one result component in sign-magnitude form, with its divider remainder
   typedef struct packed {
      logic                neg;
      logic [MAG_BITS-1:0] mag;
      logic [MAG_BITS-1:0] rem;
   } comp_type;

   // what travels along the divider chain
   typedef struct packed {
      logic                is_div;
      logic                dz;
      comp_type            re;
      comp_type            im;
      logic [MAG_BITS-1:0] den;
   } lane_type;

endpackage

### sv/cau_div_cell.sv
// one restoring-division cell: one quotient bit per component per cycle
module cau_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  cau_pkg::lane_type  in_lane,
   output logic               out_valid,
   output cau_pkg::lane_type  out_lane
);

   function automatic cau_pkg::comp_type div_step(cau_pkg::comp_type c,
                                                 logic [cau_pkg::MAG_BITS-1:0] den);
      logic [cau_pkg::MAG_BITS:0] trial;
      logic                       ge;
      cau_pkg::comp_type          r;
      trial = {c.rem, c.mag[cau_pkg::WORD_BITS-1]};
      ge    = (trial >= {1'b0, den});
      r     = c;
      if (ge) begin
         r.rem = cau_pkg::MAG_BITS'(trial - {1'b0, den});
      end else begin
         r.rem = trial[cau_pkg::MAG_BITS-1:0];
      end
      r.mag[cau_pkg::WORD_BITS-1:0] = {c.mag[cau_pkg::WORD_BITS-2:0], ge};
      return r;
   endfunction

   logic              valid_ff;
   cau_pkg::lane_type lane_ff;
   cau_pkg::lane_type lane_in;

   always_comb begin
      lane_in = in_lane;
      if (in_lane.is_div) begin
         lane_in.re = div_step(in_lane.re, in_lane.den);
         lane_in.im = div_step(in_lane.im, in_lane.den);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      lane_ff <= lane_in;
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

### sv/complex_arith_unit.sv
// top level of the complex arithmetic unit: operand stages, divider chain, saturation
//
// complex add, subtract, multiply, divide and conjugate on signed Q16.16 operands.
// busy is always low: one transaction is taken on every cycle start is high, and
// each one produces exactly one result, strobed by rsp_valid for a single cycle.
// the divider chain has one cell per quotient bit; every kind travels through
// the same chain so results leave in order. results cannot be held off, the
// receiver must take them when rsp_valid is high.
// multiply and divide truncate toward zero; an out-of-range component saturates and
// raises rsp_overflow; a zero divisor gives 0+0i with rsp_div_by_zero set
module complex_arith_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [2:0]                          req_kind,
   input  logic signed [cau_pkg::WORD_BITS-1:0] req_a_re,
   input  logic signed [cau_pkg::WORD_BITS-1:0] req_a_im,
   input  logic signed [cau_pkg::WORD_BITS-1:0] req_b_re,
   input  logic signed [cau_pkg::WORD_BITS-1:0] req_b_im,
   output logic                                rsp_valid,
   output logic signed [cau_pkg::WORD_BITS-1:0] rsp_res_re,
   output logic signed [cau_pkg::WORD_BITS-1:0] rsp_res_im,
   output logic                                rsp_overflow,
   output logic                                rsp_div_by_zero
);

   localparam int W   = cau_pkg::WORD_BITS;
   localparam int M   = cau_pkg::MAG_BITS;
   localparam int LAT = W + 5;

   // stage 1: operand capture
   logic                v1_ff;
   logic [2:0]          kind1_ff;
   logic signed [W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;

   // stage 2: products and the simple results
   logic                v2_ff;
   logic [2:0]          kind2_ff;
   logic                dz2_ff, dz2_in;
   logic signed [M-1:0] prr2_ff, pii2_ff, pri2_ff, pir2_ff, sqr2_ff, sqi2_ff;
   logic signed [W:0]   sre2_ff, sim2_ff, sre2_in, sim2_in;

   // stage 3: exact numerators and divisor
   logic                v3_ff;
   logic [2:0]          kind3_ff;
   logic                dz3_ff;
   logic signed [M:0]   nre3_ff, nim3_ff, nre3_in, nim3_in;
   logic [M-1:0]        den3_ff, den3_in;

   // stage 4 and divider chain
   logic                lane_v [W+1];
   cau_pkg::lane_type   lane   [W+1];
   logic                v4_ff;
   cau_pkg::lane_type   lane4_ff, lane4_in;

   // output register
   logic                out_v_ff;
   logic signed [W-1:0] out_re_ff, out_im_ff, out_re_in, out_im_in;
   logic                out_ovf_ff, out_dz_ff, out_ovf_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      kind1_ff <= req_kind;
      ar1_ff   <= req_a_re;
      ai1_ff   <= req_a_im;
      br1_ff   <= req_b_re;
      bi1_ff   <= req_b_im;
   end

   // stage 2: six signed products, add/sub/conjugate done here too
   always_comb begin
      sre2_in = '0;
      sim2_in = '0;
      case (kind1_ff)
         cau_pkg::KIND_ADD: begin
            sre2_in = (W+1)'(ar1_ff) + (W+1)'(br1_ff);
            sim2_in = (W+1)'(ai1_ff) + (W+1)'(bi1_ff);
         end
         cau_pkg::KIND_SUB: begin
            sre2_in = (W+1)'(ar1_ff) - (W+1)'(br1_ff);
            sim2_in = (W+1)'(ai1_ff) - (W+1)'(bi1_ff);
         end
         cau_pkg::KIND_CONJ: begin
            sre2_in = (W+1)'(ar1_ff);
            sim2_in = -((W+1)'(ai1_ff));
         end
         default: begin
            sre2_in = '0;
            sim2_in = '0;
         end
      endcase
      dz2_in = (kind1_ff == cau_pkg::KIND_DIV) && (br1_ff == '0) && (bi1_ff == '0);
   end

   always_ff @(posedge clock) begin
      kind2_ff <= kind1_ff;
      dz2_ff   <= dz2_in;
      prr2_ff  <= M'(ar1_ff) * M'(br1_ff);
      pii2_ff  <= M'(ai1_ff) * M'(bi1_ff);
      pri2_ff  <= M'(ar1_ff) * M'(bi1_ff);
      pir2_ff  <= M'(ai1_ff) * M'(br1_ff);
      sqr2_ff  <= M'(br1_ff) * M'(br1_ff);
      sqi2_ff  <= M'(bi1_ff) * M'(bi1_ff);
      sre2_ff  <= sre2_in;
      sim2_ff  <= sim2_in;
   end

   // stage 3: combine products into exact real and imaginary parts
   always_comb begin
      case (kind2_ff)
         cau_pkg::KIND_MUL: begin
            nre3_in = (M+1)'(prr2_ff) - (M+1)'(pii2_ff);
            nim3_in = (M+1)'(pri2_ff) + (M+1)'(pir2_ff);
         end
         cau_pkg::KIND_DIV: begin
            nre3_in = (M+1)'(prr2_ff) + (M+1)'(pii2_ff);
            nim3_in = (M+1)'(pir2_ff) - (M+1)'(pri2_ff);
         end
         default: begin
            nre3_in = (M+1)'(sre2_ff);
            nim3_in = (M+1)'(sim2_ff);
         end
      endcase
      den3_in = M'(sqr2_ff) + M'(sqi2_ff);
   end

   always_ff @(posedge clock) begin
      kind3_ff <= kind2_ff;
      dz3_ff   <= dz2_ff;
      nre3_ff  <= nre3_in;
      nim3_ff  <= nim3_in;
      den3_ff  <= den3_in;
   end

   // stage 4: sign-magnitude split, quotient range check, divider seed
   function automatic cau_pkg::comp_type prep(logic signed [M:0] val, logic [2:0] kind,
                                             logic [M-1:0] den, logic dz);
      logic              neg;
      logic [M:0]        absv;
      logic [M-1:0]      a;
      logic              big;
      cau_pkg::comp_type c;
      neg   = val[M];
      absv  = neg ? -val : val;
      a     = absv[M-1:0];
      big   = {{cau_pkg::SHIFT_BITS{1'b0}}, a} >= {den, {cau_pkg::SHIFT_BITS{1'b0}}};
      c.neg = neg;
      c.rem = '0;
      case (kind)
         cau_pkg::KIND_MUL: c.mag = a >> cau_pkg::FRAC_BITS;
         cau_pkg::KIND_DIV: begin
            // upper half flags a quotient past the word, lower half shifts out
            // the remaining dividend bits and takes in the quotient bits
            c.mag = {(W)'(big), W'(a << cau_pkg::FRAC_BITS)};
            c.rem = a >> cau_pkg::SHIFT_BITS;
            if (dz) begin
               c.mag = '0;
            end
         end
         default: c.mag = a;
      endcase
      return c;
   endfunction

   always_comb begin
      lane4_in.is_div = (kind3_ff == cau_pkg::KIND_DIV) && !dz3_ff;
      lane4_in.dz     = dz3_ff;
      lane4_in.re     = prep(nre3_ff, kind3_ff, den3_ff, dz3_ff);
      lane4_in.im     = prep(nim3_ff, kind3_ff, den3_ff, dz3_ff);
      lane4_in.den    = den3_ff;
   end

   always_ff @(posedge clock) begin
      lane4_ff <= lane4_in;
   end

   assign lane_v[0] = v4_ff;
   assign lane[0]   = lane4_ff;

   // one cell per quotient bit; other kinds pass along untouched
   for (genvar g = 0; g < W; g++) begin : g_cell
      cau_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lane_v[g]),
         .in_lane   (lane[g]),
         .out_valid (lane_v[g+1]),
         .out_lane  (lane[g+1])
      );
   end

   // saturation to the signed word range
   function automatic logic [W:0] finish(cau_pkg::comp_type c);
      logic [M-1:0] limit;
      logic [M-1:0] m;
      logic         sat;
      limit = c.neg ? (M'(1) << (W - 1)) : ((M'(1) << (W - 1)) - M'(1));
      sat   = c.mag > limit;
      m     = sat ? limit : c.mag;
      return {sat, (c.neg ? W'(-m) : W'(m))};
   endfunction

   logic [W:0] fin_re, fin_im;

   always_comb begin
      fin_re     = finish(lane[W].re);
      fin_im     = finish(lane[W].im);
      out_re_in  = fin_re[W-1:0];
      out_im_in  = fin_im[W-1:0];
      out_ovf_in = fin_re[W] || fin_im[W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= lane_v[W];
      end
      out_re_ff  <= out_re_in;
      out_im_ff  <= out_im_in;
      out_ovf_ff <= out_ovf_in;
      out_dz_ff  <= lane[W].dz;
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_res_re      = out_re_ff;
   assign rsp_res_im      = out_im_ff;
   assign rsp_overflow    = out_ovf_ff;
   assign rsp_div_by_zero = out_dz_ff;

   // every transaction comes out after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result missing after fixed latency");

   // a zero divisor never reports saturation
   a_dz_no_ovf : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_div_by_zero && rsp_overflow))
      else $error("div_by_zero together with overflow");

   // a zero divisor returns zero
   a_dz_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_by_zero) |-> (rsp_res_re == '0 && rsp_res_im == '0))
      else $error("nonzero result on zero divisor");

endmodule
